// ===== sv/lzss_pkg.sv =====
// ============================================================================
// LZSS decompressor package
// Shared constants, state encodings and the controller/datapath interface.
// ============================================================================
package lzss_pkg;

    localparam int OFFSET_BITS_DEF = 10;
    localparam int MIN_MATCH_DEF   = 3;
    localparam int SIZE_W          = 32;

    // Position in the compressed object.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_FLAG,
        PH_DATA,
        PH_TOKHI
    } t_phase;

    // Sequencing of the controller.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_ACCEPT,
        S_READ,
        S_WRITE
    } t_ctrl_state;

    typedef struct packed {
        logic clr_step;
        logic hdr_load;
        logic flag_load;
        logic tok_low_load;
        logic literal;
        logic copy_start;
        logic copy_read;
        logic copy_write;
        logic adv_flag;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic hdr_last;
        logic hdr_zero;
        logic flag_bit;
        logic pos_last;
        logic remain_one;
        logic copy_end;
        logic out_free;
    } t_dp_status;

endpackage

// ===== sv/lzss_ctrl.sv =====
// ============================================================================
// LZSS controller
// Tracks the parse phase of the object and sequences clearing and copies.
// ============================================================================
module lzss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_start,
    input  lzss_pkg::t_dp_status i_status,
    output logic                 o_s_axis_tready,
    output lzss_pkg::t_dp_cmd    o_cmd
);
    import lzss_pkg::*;

    t_ctrl_state r_state, n_state;
    t_phase      r_phase, n_phase;
    t_phase      eff_phase;
    t_phase      adv_phase;
    logic        accept;

    assign o_s_axis_tready = (r_state == S_ACCEPT) && i_status.out_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    // A start request always restarts the header, whatever came before.
    assign eff_phase       = i_start ? PH_HEADER : r_phase;
    assign adv_phase       = i_status.remain_one ? PH_IDLE :
                             (i_status.pos_last ? PH_FLAG : PH_DATA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = S_ACCEPT;
                end
            end
            S_ACCEPT: begin
                if (accept) begin
                    case (eff_phase)
                        PH_HEADER: begin
                            if (i_status.hdr_last) begin
                                n_phase = i_status.hdr_zero ? PH_IDLE : PH_FLAG;
                            end else begin
                                n_phase = PH_HEADER;
                            end
                        end
                        PH_FLAG: n_phase = PH_DATA;
                        PH_DATA: begin
                            n_phase = i_status.flag_bit ? PH_TOKHI : adv_phase;
                        end
                        PH_TOKHI: n_state = S_READ;
                        default: n_phase = r_phase;
                    endcase
                end
            end
            S_READ: n_state = S_WRITE;
            S_WRITE: begin
                if (i_status.out_free) begin
                    if (i_status.copy_end) begin
                        n_state = S_ACCEPT;
                        n_phase = adv_phase;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_ACCEPT: begin
                if (accept) begin
                    case (eff_phase)
                        PH_HEADER: o_cmd.hdr_load = 1'b1;
                        PH_FLAG:   o_cmd.flag_load = 1'b1;
                        PH_DATA: begin
                            if (i_status.flag_bit) begin
                                o_cmd.tok_low_load = 1'b1;
                            end else begin
                                o_cmd.literal  = 1'b1;
                                o_cmd.adv_flag = 1'b1;
                            end
                        end
                        PH_TOKHI: o_cmd.copy_start = 1'b1;
                        default: o_cmd = '0;
                    endcase
                end
            end
            S_READ: o_cmd.copy_read = 1'b1;
            S_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.copy_write = 1'b1;
                    o_cmd.adv_flag   = i_status.copy_end;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/lzss_datapath.sv =====
// ============================================================================
// LZSS datapath
// History memory, size and flag registers, copy counters and result register.
// ============================================================================
module lzss_datapath #(
    parameter int OFFSET_BITS = lzss_pkg::OFFSET_BITS_DEF,
    parameter int MIN_MATCH   = lzss_pkg::MIN_MATCH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_data,
    input  logic                 i_start,
    input  lzss_pkg::t_dp_cmd    i_cmd,
    output lzss_pkg::t_dp_status o_status,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_out_a,
    output logic [7:0]           o_out_b,
    output logic [1:0]           o_count,
    output logic                 o_run_last,
    output logic                 o_obj_last
);
    import lzss_pkg::*;

    localparam int DEPTH = 1 << OFFSET_BITS;
    localparam int LEN_W = 17 - OFFSET_BITS;

    logic [7:0]             r_mem [DEPTH];
    logic [7:0]             r_rd_data;
    logic [OFFSET_BITS-1:0] r_clr_addr;
    logic [OFFSET_BITS-1:0] r_wp;
    logic [OFFSET_BITS-1:0] r_off;
    logic [LEN_W-1:0]       r_len;
    logic [SIZE_W-1:0]      r_remain;
    logic [1:0]             r_hdr_idx;
    logic [7:0]             r_flag_bits;
    logic [2:0]             r_flag_pos;
    logic [7:0]             r_token_low;
    logic [7:0]             r_pair_a;
    logic                   r_pair_k;
    logic                   r_ov;
    logic [7:0]             r_oa;
    logic [7:0]             r_ob;
    logic [1:0]             r_ocnt;
    logic                   r_orl;
    logic                   r_ool;

    logic                   w_en;
    logic [OFFSET_BITS-1:0] w_addr;
    logic [7:0]             w_data;
    logic [OFFSET_BITS-1:0] rd_addr;
    logic [SIZE_W-1:0]      hdr_base;
    logic [SIZE_W-1:0]      hdr_value;
    logic [15:0]            token;
    logic [LEN_W-1:0]       tok_len;
    logic                   emit_cp;
    logic                   out_free;

    // The size arrives low byte first, so it is shifted in from the top.
    assign hdr_base  = i_start ? '0 : r_remain;
    assign hdr_value = {i_data, hdr_base[SIZE_W-1:8]};
    assign token     = {i_data, r_token_low};
    assign tok_len   = LEN_W'(token[15:OFFSET_BITS]) + LEN_W'(MIN_MATCH);
    assign rd_addr   = r_wp + r_off;
    assign out_free  = !r_ov || i_m_axis_tready;

    always_comb begin
        o_status.clr_done   = (r_clr_addr == '1);
        o_status.hdr_last   = !i_start && (r_hdr_idx == 2'd3);
        o_status.hdr_zero   = (hdr_value == '0);
        o_status.flag_bit   = r_flag_bits[r_flag_pos];
        o_status.pos_last   = (r_flag_pos == 3'd7);
        o_status.remain_one = (r_remain == SIZE_W'(1));
        o_status.copy_end   = (r_len == LEN_W'(1)) || (r_remain == SIZE_W'(1));
        o_status.out_free   = out_free;
    end

    // A result leaves once a pair is complete or the copy has ended.
    assign emit_cp = i_cmd.copy_write && (r_pair_k || o_status.copy_end);

    always_comb begin
        w_en   = i_cmd.clr_step || i_cmd.literal || i_cmd.copy_write;
        w_addr = i_cmd.clr_step ? r_clr_addr : r_wp;
        if (i_cmd.literal) begin
            w_data = i_data;
        end else if (i_cmd.copy_write) begin
            w_data = r_rd_data;
        end else begin
            w_data = 8'd0;
        end
    end

    // The source byte is registered in S_READ before S_WRITE writes it back,
    // so a copy that overlaps its own output sees the byte written just before.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_cmd.copy_read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_remain    <= '0;
            r_hdr_idx   <= '0;
            r_flag_bits <= '0;
            r_flag_pos  <= '0;
            r_token_low <= '0;
            r_len       <= '0;
            r_pair_k    <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.hdr_load) begin
                r_remain <= hdr_value;
                if (o_status.hdr_last) begin
                    r_hdr_idx <= '0;
                end else if (i_start) begin
                    r_hdr_idx <= 2'd1;
                end else begin
                    r_hdr_idx <= r_hdr_idx + 1'b1;
                end
            end
            if (i_cmd.flag_load) begin
                r_flag_bits <= i_data;
                r_flag_pos  <= '0;
            end
            if (i_cmd.adv_flag) begin
                r_flag_pos <= r_flag_pos + 1'b1;
            end
            if (i_cmd.tok_low_load) begin
                r_token_low <= i_data;
            end
            if (i_cmd.literal) begin
                r_wp     <= r_wp + 1'b1;
                r_remain <= r_remain - 1'b1;
            end
            if (i_cmd.copy_start) begin
                r_off    <= token[OFFSET_BITS-1:0];
                r_len    <= tok_len;
                r_pair_k <= 1'b0;
            end
            if (i_cmd.copy_write) begin
                r_wp     <= r_wp + 1'b1;
                r_remain <= r_remain - 1'b1;
                r_len    <= r_len - 1'b1;
                r_pair_k <= o_status.copy_end ? 1'b0 : !r_pair_k;
                if (!r_pair_k) begin
                    r_pair_a <= r_rd_data;
                end
            end
            if (i_cmd.literal || emit_cp) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.literal) begin
            r_oa   <= i_data;
            r_ob   <= 8'd0;
            r_ocnt <= 2'd1;
            r_orl  <= 1'b1;
            r_ool  <= o_status.remain_one;
        end else if (emit_cp) begin
            r_oa   <= r_pair_k ? r_pair_a : r_rd_data;
            r_ob   <= r_pair_k ? r_rd_data : 8'd0;
            r_ocnt <= r_pair_k ? 2'd2 : 2'd1;
            r_orl  <= o_status.copy_end;
            r_ool  <= o_status.remain_one;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_out_a         = r_oa;
    assign o_out_b         = r_ob;
    assign o_count         = r_ocnt;
    assign o_run_last      = r_orl;
    assign o_obj_last      = r_ool;

    a_write_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.copy_write |-> out_free)
        else $error("copy byte written while the result register is occupied");

    a_read_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.copy_read |-> (r_remain != '0) && (r_len != '0))
        else $error("copy read with no length or size left");

    a_object_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ool) |-> (r_remain == '0))
        else $error("object end flagged while bytes remain");

    a_pair_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.copy_write && o_status.copy_end) |=> !r_pair_k)
        else $error("half pair left over after the copy ended");

endmodule

// ===== sv/lzss_stream_decompressor.sv =====
// ============================================================================
// LZSS stream decompressor
// Decodes size header, flag bytes, literals and back-reference tokens into a
// stream of one- or two-byte results.
// ============================================================================
// Header, flag and token-low bytes only load registers; a literal's result is
// registered and valid the cycle after the request is taken.
// A token's copy reads each output byte from the history into a register
// and then writes it back, and input is held until the copy has ended,
// which the declared size can cut short and any output stall can delay.
// After reset all 2^OFFSET_BITS history entries are cleared, one a cycle.
module lzss_stream_decompressor #(
    parameter int OFFSET_BITS = lzss_pkg::OFFSET_BITS_DEF,
    parameter int MIN_MATCH   = lzss_pkg::MIN_MATCH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] start_req
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] out_byte_a, [15:8] out_byte_b
    output logic        o_m_axis_tlast,   // run_last
    output logic [2:0]  o_m_axis_tuser    // [1:0] byte_count, [2] object_last
);
    import lzss_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [1:0] out_count;
    logic       out_obj_last;

    lzss_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_start         (i_s_axis_tuser),
        .i_status        (status),
        .o_s_axis_tready (o_s_axis_tready),
        .o_cmd           (cmd)
    );

    lzss_datapath #(
        .OFFSET_BITS (OFFSET_BITS),
        .MIN_MATCH   (MIN_MATCH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_data          (i_s_axis_tdata),
        .i_start         (i_s_axis_tuser),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_out_a         (out_a),
        .o_out_b         (out_b),
        .o_count         (out_count),
        .o_run_last      (o_m_axis_tlast),
        .o_obj_last      (out_obj_last)
    );

    assign o_m_axis_tdata = {out_b, out_a};
    assign o_m_axis_tuser = {out_obj_last, out_count};

endmodule

// ===== dv/tb_lzss_stream_decompressor.sv =====
// ============================================================================
// LZSS stream decompressor testbench
// Drives compressed objects into the decoder and predicts every output pair
// from a behavioural decoder with its own history window. Directed tests
// cover the special cases, then random well-formed objects with some noise
// run with random gaps on both buses and one long output stall, then without gaps.
// ============================================================================
module tb_lzss_stream_decompressor;

    import lzss_pkg::*;

    localparam int WIN_SIZE    = 1 << OFFSET_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [1:0] count;
        logic       run_last;
        logic       obj_last;
    } t_out_pair;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_s_axis_tvalid  = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata   = 8'h00;  // [7:0] data_byte
    logic        i_s_axis_tuser   = 1'b0;   // [0] start_req
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready  = 1'b0;
    logic [15:0] o_m_axis_tdata;            // [7:0] out_byte_a, [15:8] out_byte_b
    logic        o_m_axis_tlast;            // run_last
    logic [2:0]  o_m_axis_tuser;            // [1:0] byte_count, [2] object_last

    // Behavioural decoder state.
    t_phase                     dec_phase;
    logic [1:0]                 hdr_count;
    logic [31:0]                size_goal;
    logic [31:0]                bytes_out;
    logic [7:0]                 flag_reg;
    logic [2:0]                 flag_idx;
    logic [7:0]                 token_lo;
    logic [7:0]                 window [0:WIN_SIZE-1];
    logic [OFFSET_BITS_DEF-1:0] win_ptr;

    t_out_pair predicted_pairs [$];

    bit tx_gaps_on     = 1'b0;
    bit rx_stall_on    = 1'b0;
    int rx_hold_cycles = 0;
    int rx_gap_left    = 0;
    int err_count      = 0;
    int cycle_count    = 0;
    int accepted_items = 0;
    int pairs_checked  = 0;
    int objects_begun  = 0;

    lzss_stream_decompressor uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pairs still awaited",
                     cycle_count, predicted_pairs.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Behavioural decoder
    // ------------------------------------------------------------------------
    task automatic store_byte(input logic [7:0] v);
        window[win_ptr] = v;
        win_ptr++;
        bytes_out++;
    endtask

    task automatic next_flag();
        if (bytes_out >= size_goal) begin
            dec_phase = PH_IDLE;
        end else if (flag_idx == 3'd7) begin
            flag_idx  = 3'd0;
            dec_phase = PH_FLAG;
        end else begin
            flag_idx++;
            dec_phase = PH_DATA;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic st, output bit ignored);
        logic [15:0]                tok;
        logic [OFFSET_BITS_DEF-1:0] src;
        logic [7:0]                 v;
        int                         len;
        int                         j;
        int                         k;
        t_out_pair                  cur;
        t_out_pair                  held;
        bit                         have_held;
        ignored   = 1'b0;
        have_held = 1'b0;
        if (st) begin
            dec_phase = PH_HEADER;
            hdr_count = 2'd0;
            size_goal = 32'd0;
            bytes_out = 32'd0;
        end
        case (dec_phase)
            PH_HEADER: begin
                size_goal = size_goal | (32'(b) << (8 * hdr_count));
                if (hdr_count == 2'd3) begin
                    hdr_count = 2'd0;
                    dec_phase = (size_goal == 32'd0) ? PH_IDLE : PH_FLAG;
                end else begin
                    hdr_count++;
                end
            end
            PH_FLAG: begin
                flag_reg  = b;
                flag_idx  = 3'd0;
                dec_phase = PH_DATA;
            end
            PH_DATA: begin
                if (flag_reg[flag_idx]) begin
                    token_lo  = b;
                    dec_phase = PH_TOKHI;
                end else begin
                    store_byte(b);
                    cur.byte_a   = b;
                    cur.byte_b   = 8'h00;
                    cur.count    = 2'd1;
                    cur.run_last = 1'b1;
                    cur.obj_last = (bytes_out >= size_goal);
                    predicted_pairs.push_back(cur);
                    next_flag();
                end
            end
            PH_TOKHI: begin
                tok = {b, token_lo};
                len = int'(tok >> OFFSET_BITS_DEF) + MIN_MATCH_DEF;
                j   = 0;
                // The last pair of a copy is held back so that it can carry tlast.
                while (j < len && bytes_out < size_goal) begin
                    cur = '0;
                    k   = 0;
                    while (k < 2 && j < len && bytes_out < size_goal) begin
                        src = win_ptr + tok[OFFSET_BITS_DEF-1:0];
                        v   = window[src];
                        store_byte(v);
                        if (k == 0) cur.byte_a = v;
                        else cur.byte_b = v;
                        k++;
                        j++;
                    end
                    cur.count    = 2'(k);
                    cur.obj_last = (bytes_out >= size_goal);
                    if (have_held) predicted_pairs.push_back(held);
                    held      = cur;
                    have_held = 1'b1;
                end
                if (have_held) begin
                    held.run_last = 1'b1;
                    predicted_pairs.push_back(held);
                end
                next_flag();
            end
            default: ignored = 1'b1;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Output checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_pair want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (predicted_pairs.size() == 0) begin
                report_error($sformatf("unexpected result, tdata %04h tuser %0h tlast %0b",
                                       o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast));
            end else begin
                want = predicted_pairs.pop_front();
                if (o_m_axis_tdata[7:0] !== want.byte_a)
                    report_error($sformatf("pair %0d out_byte_a %02h, expected %02h",
                                           pairs_checked, o_m_axis_tdata[7:0], want.byte_a));
                if (o_m_axis_tdata[15:8] !== want.byte_b)
                    report_error($sformatf("pair %0d out_byte_b %02h, expected %02h",
                                           pairs_checked, o_m_axis_tdata[15:8], want.byte_b));
                if (o_m_axis_tuser[1:0] !== want.count)
                    report_error($sformatf("pair %0d byte_count %0d, expected %0d",
                                           pairs_checked, o_m_axis_tuser[1:0], want.count));
                if (o_m_axis_tlast !== want.run_last)
                    report_error($sformatf("pair %0d run_last %0b, expected %0b",
                                           pairs_checked, o_m_axis_tlast, want.run_last));
                if (o_m_axis_tuser[2] !== want.obj_last)
                    report_error($sformatf("pair %0d object_last %0b, expected %0b",
                                           pairs_checked, o_m_axis_tuser[2], want.obj_last));
            end
            pairs_checked++;
        end
    end

    // Output ready: a requested long hold first, then random short stalls while enabled.
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
            rx_gap_left = $urandom_range(0, 14);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic st);
        int gap;
        bit ignored;
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= st;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        decode_byte(b, st, ignored);
        if (!ignored) accepted_items++;
    endtask

    task automatic send_header(input logic [31:0] size);
        send_item(size[7:0], 1'b1);
        send_item(size[15:8], 1'b0);
        send_item(size[23:16], 1'b0);
        send_item(size[31:24], 1'b0);
        objects_begun++;
    endtask

    function automatic logic [15:0] make_token(input int len, input int off);
        return 16'(((len - MIN_MATCH_DEF) << OFFSET_BITS_DEF) | off);
    endfunction

    // Lowers valid in the step of the last request and waits for every pair.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (predicted_pairs.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_idle_and_empty();
        send_item(8'h5a, 1'b0);        // no object open, so nothing comes out
        send_header(32'd0);            // an empty object ends after its size
    endtask

    task automatic test_literal_copy_truncate();
        logic [15:0] tok;
        send_header(32'd9);
        send_item(8'h06, 1'b0);        // literal, token, token
        send_item(8'hff, 1'b0);
        // Reads positions that have never been written and so hold zero.
        tok = make_token(3, 512);
        send_item(tok[7:0], 1'b0);
        send_item(tok[15:8], 1'b0);
        // Overlapping copy of maximal length, cut short by the declared size.
        tok = make_token(66, WIN_SIZE - 4);
        send_item(tok[7:0], 1'b0);
        send_item(tok[15:8], 1'b0);
        send_item(8'h33, 1'b0);        // object complete: ignored
    endtask

    task automatic test_longest_copy();
        logic [15:0] tok;
        send_header(32'd100);
        send_item(8'h01, 1'b0);
        tok = make_token(66, WIN_SIZE - 9);
        send_item(tok[7:0], 1'b0);
        send_item(tok[15:8], 1'b0);
        send_item(8'haa, 1'b0);
        // The object stays open; the next test continues it or restarts in the middle of it.
    endtask

    task automatic send_random_stream(input int n_items);
        int                         goal;
        int                         obj_items;
        int                         r;
        logic [31:0]                next_size;
        logic [15:0]                tok_word;
        logic [OFFSET_BITS_DEF-1:0] off;
        logic [5:0]                 len_f;
        goal      = accepted_items + n_items;
        obj_items = 0;
        next_size = 32'd0;
        tok_word  = 16'h0000;
        while (accepted_items < goal) begin
            r = $urandom_range(0, 39);
            if (dec_phase == PH_IDLE && $urandom_range(0, 4) == 0) begin
                send_item(8'($urandom), 1'b0);
            end else if (dec_phase == PH_IDLE || obj_items > 60 || r == 0) begin
                case ($urandom_range(0, 19))
                    0:       next_size = 32'd0;
                    1:       next_size = $urandom;
                    2, 3, 4: next_size = $urandom_range(41, 400);
                    default: next_size = $urandom_range(1, 40);
                endcase
                send_item(next_size[7:0], 1'b1);
                objects_begun++;
                obj_items = 1;
            end else begin
                if (r == 1) begin
                    // Broken sequence: a stray byte, possibly a stray restart.
                    send_item(8'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    case (dec_phase)
                        PH_HEADER: send_item(next_size[8 * hdr_count +: 8], 1'b0);
                        PH_FLAG: begin
                            case ($urandom_range(0, 3))
                                0:       send_item(8'h00, 1'b0);
                                1:       send_item(8'hff, 1'b0);
                                default: send_item(8'($urandom), 1'b0);
                            endcase
                        end
                        PH_DATA: begin
                            if (flag_reg[flag_idx]) begin
                                if ($urandom_range(0, 2) == 0)
                                    off = OFFSET_BITS_DEF'($urandom);
                                else
                                    off = OFFSET_BITS_DEF'(WIN_SIZE - $urandom_range(1, 24));
                                if ($urandom_range(0, 4) == 0)
                                    len_f = 6'($urandom_range(0, 63));
                                else
                                    len_f = 6'($urandom_range(0, 5));
                                tok_word = 16'((int'(len_f) << OFFSET_BITS_DEF) | int'(off));
                                send_item(tok_word[7:0], 1'b0);
                            end else begin
                                send_item(8'($urandom), 1'b0);
                            end
                        end
                        PH_TOKHI: send_item(tok_word[15:8], 1'b0);
                        default: ;
                    endcase
                end
                obj_items++;
            end
        end
    endtask

    task automatic test_random_objects();
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        send_random_stream(70);
    endtask

    task automatic test_output_backpressure();
        // The output is held off while requests keep coming, so the decoder
        // fills up and must stall its input.
        rx_hold_cycles = 400;
        send_random_stream(25);
        wait_drained();
    endtask

    task automatic test_full_rate();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        send_random_stream(40);
    endtask

    initial begin
        int i;
        dec_phase = PH_IDLE;
        hdr_count = 2'd0;
        size_goal = 32'd0;
        bytes_out = 32'd0;
        flag_reg  = 8'h00;
        flag_idx  = 3'd0;
        token_lo  = 8'h00;
        win_ptr   = '0;
        for (i = 0; i < WIN_SIZE; i++) window[i] = 8'h00;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_empty();
        test_literal_copy_truncate();
        test_longest_copy();
        test_random_objects();
        test_output_backpressure();
        test_full_rate();

        wait_drained();
        repeat (80) @(posedge i_clk);

        $display("Decoded %0d requests into %0d output pairs across %0d objects,",
                 accepted_items, pairs_checked, objects_begun);
        $display("with restarts, truncated and overlapping copies, and a long output stall.");
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors", err_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
